// File: hw/rtl/vector_scale_to_length_top_macros.svh
// ---------------------------------------------------------------------------
// Vector scale-to-length assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef VECTOR_SCALE_TO_LENGTH_TOP_MACROS_SVH
`define VECTOR_SCALE_TO_LENGTH_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VSTL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VSTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/vstl_pkg.sv
// ---------------------------------------------------------------------------
// Vector scale-to-length package
// Shared constants and the side-band struct that travels with each item.
// ---------------------------------------------------------------------------
`default_nettype none

package vstl_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int OUT_BITS        = 17;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic zero;
  } side_t;

endpackage

`default_nettype wire

// File: hw/rtl/vstl_prep.sv
// ---------------------------------------------------------------------------
// Vector scale-to-length front end
// Magnitudes, squared norm, scaled components and the squared dividends.
// ---------------------------------------------------------------------------
`default_nettype none

module vstl_prep #(
  parameter int COORD_BITS  = vstl_pkg::COORD_BITS_DEF,
  parameter int LENGTH_BITS = vstl_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     en,
  input  wire logic                                     v_i,
  input  wire logic [COORD_BITS-1:0]                    x_i,
  input  wire logic [COORD_BITS-1:0]                    y_i,
  input  wire logic [LENGTH_BITS-1:0]                   len_i,
  output logic                                          v_o,
  output vstl_pkg::side_t                               side_o,
  output logic [2*COORD_BITS-1:0]                       s_o,
  output logic [2*(LENGTH_BITS+COORD_BITS)+1:0]         nx_o,
  output logic [2*(LENGTH_BITS+COORD_BITS)+1:0]         ny_o
);

  localparam int CB = COORD_BITS;
  localparam int LB = LENGTH_BITS;
  localparam int SB = 2 * CB;
  localparam int QB = LB + CB;
  localparam int NB = 2 * QB + 2;
  localparam logic [CB-1:0] ONE_C = CB'(1);

  logic           xneg, yneg;
  logic [CB-1:0]  xm, ym;

  logic           v1_r;
  vstl_pkg::side_t side1_r;
  logic [CB-1:0]  xm1_r, ym1_r;
  logic [LB-1:0]  len1_r;

  logic           v2_r;
  vstl_pkg::side_t side2_r;
  logic [SB-1:0]  s2_r;
  logic [QB-1:0]  qx2_r, qy2_r;

  logic           v3_r;
  vstl_pkg::side_t side3_r;
  logic [SB-1:0]  s3_r;
  logic [NB-1:0]  nx3_r, ny3_r;

  logic [SB-1:0]  sqx, sqy;
  logic [QB-1:0]  qx, qy;
  logic [2*QB-1:0] qqx, qqy;

  always_comb begin
    xneg = x_i[CB-1];
    yneg = y_i[CB-1];
    xm   = xneg ? (~x_i + ONE_C) : x_i;
    ym   = yneg ? (~y_i + ONE_C) : y_i;
    sqx  = {{CB{1'b0}}, xm1_r} * {{CB{1'b0}}, xm1_r};
    sqy  = {{CB{1'b0}}, ym1_r} * {{CB{1'b0}}, ym1_r};
    qx   = {{CB{1'b0}}, len1_r} * {{LB{1'b0}}, xm1_r};
    qy   = {{CB{1'b0}}, len1_r} * {{LB{1'b0}}, ym1_r};
    qqx  = {{QB{1'b0}}, qx2_r} * {{QB{1'b0}}, qx2_r};
    qqy  = {{QB{1'b0}}, qy2_r} * {{QB{1'b0}}, qy2_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r.xneg <= xneg;
      side1_r.yneg <= yneg;
      side1_r.zero <= (x_i == '0) && (y_i == '0);
      xm1_r        <= xm;
      ym1_r        <= ym;
      len1_r       <= len_i;
      side2_r      <= side1_r;
      s2_r         <= sqx + sqy;
      qx2_r        <= qx;
      qy2_r        <= qy;
      side3_r      <= side2_r;
      s3_r         <= s2_r;
      nx3_r        <= {qqx, 2'b00};
      ny3_r        <= {qqy, 2'b00};
    end
  end

  assign v_o    = v3_r;
  assign side_o = side3_r;
  assign s_o    = s3_r;
  assign nx_o   = nx3_r;
  assign ny_o   = ny3_r;

endmodule

`default_nettype wire

// File: hw/rtl/vstl_div.sv
// ---------------------------------------------------------------------------
// Vector scale-to-length divider
// Pipelined restoring divider, one quotient bit per stage, two lanes.
// ---------------------------------------------------------------------------
`default_nettype none
`include "vector_scale_to_length_top_macros.svh"

module vstl_div #(
  parameter int SB = 32,
  parameter int TB = 34
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              v_i,
  input  wire vstl_pkg::side_t   side_i,
  input  wire logic [SB-1:0]     d_i,
  input  wire logic [SB+TB-1:0]  nx_i,
  input  wire logic [SB+TB-1:0]  ny_i,
  output logic                   v_o,
  output vstl_pkg::side_t        side_o,
  output logic [TB-1:0]          qx_o,
  output logic [TB-1:0]          qy_o
);

  // Each nq register starts with the low dividend bits and ends as the quotient.
  logic            v_r    [TB+1];
  vstl_pkg::side_t side_r [TB+1];
  logic [SB-1:0]   d_r    [TB+1];
  logic [SB-1:0]   remx_r [TB+1];
  logic [SB-1:0]   remy_r [TB+1];
  logic [TB-1:0]   nqx_r  [TB+1];
  logic [TB-1:0]   nqy_r  [TB+1];

  function automatic logic [SB+TB-1:0] div_step(input logic [SB-1:0] rem,
                                                input logic [TB-1:0] nq,
                                                input logic [SB-1:0] d);
    logic [SB:0] r2;
    logic [SB:0] dd;
    logic        ge;
    r2 = {rem, nq[TB-1]};
    dd = {1'b0, d};
    ge = (r2 >= dd);
    if (ge) begin
      r2 = r2 - dd;
    end
    return {r2[SB-1:0], nq[TB-2:0], ge};
  endfunction

  // The quotient is known to fit in TB bits, so the top dividend bits
  // are already below the divisor and seed the remainder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      d_r[0]    <= d_i;
      remx_r[0] <= nx_i[SB+TB-1:TB];
      remy_r[0] <= ny_i[SB+TB-1:TB];
      nqx_r[0]  <= nx_i[TB-1:0];
      nqy_r[0]  <= ny_i[TB-1:0];
    end
  end

  for (genvar i = 1; i <= TB; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i]              <= side_r[i-1];
        d_r[i]                 <= d_r[i-1];
        {remx_r[i], nqx_r[i]}  <= div_step(remx_r[i-1], nqx_r[i-1], d_r[i-1]);
        {remy_r[i], nqy_r[i]}  <= div_step(remy_r[i-1], nqy_r[i-1], d_r[i-1]);
      end
    end
  end

  assign v_o    = v_r[TB];
  assign side_o = side_r[TB];
  assign qx_o   = nqx_r[TB];
  assign qy_o   = nqy_r[TB];

  `VSTL_ASSERT_NOW(a_div_remx_below, v_r[TB] && !side_r[TB].zero, remx_r[TB] < d_r[TB], "x remainder not below divisor")
  `VSTL_ASSERT_NOW(a_div_remy_below, v_r[TB] && !side_r[TB].zero, remy_r[TB] < d_r[TB], "y remainder not below divisor")

endmodule

`default_nettype wire

// File: hw/rtl/vstl_isqrt.sv
// ---------------------------------------------------------------------------
// Vector scale-to-length integer square root
// Pipelined digit-by-digit root, one root bit per stage, two lanes.
// ---------------------------------------------------------------------------
`default_nettype none

module vstl_isqrt #(
  parameter int TB = 34
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              v_i,
  input  wire vstl_pkg::side_t   side_i,
  input  wire logic [TB-1:0]     tx_i,
  input  wire logic [TB-1:0]     ty_i,
  output logic                   v_o,
  output vstl_pkg::side_t        side_o,
  output logic [TB/2-1:0]        kx_o,
  output logic [TB/2-1:0]        ky_o
);

  localparam int KB = TB / 2;
  localparam int RB = KB + 2;

  logic            v_r    [KB+1];
  vstl_pkg::side_t side_r [KB+1];
  logic [RB-1:0]   remx_r [KB+1];
  logic [RB-1:0]   remy_r [KB+1];
  logic [KB-1:0]   rtx_r  [KB+1];
  logic [KB-1:0]   rty_r  [KB+1];
  logic [TB-1:0]   tx_r   [KB+1];
  logic [TB-1:0]   ty_r   [KB+1];

  function automatic logic [RB+KB+TB-1:0] sq_step(input logic [RB-1:0] rem,
                                                  input logic [KB-1:0] root,
                                                  input logic [TB-1:0] t);
    logic [RB+1:0] r4;
    logic [RB+1:0] trial;
    logic          ge;
    r4    = {rem, t[TB-1:TB-2]};
    trial = {2'b00, root, 2'b01};
    ge    = (r4 >= trial);
    if (ge) begin
      r4 = r4 - trial;
    end
    return {r4[RB-1:0], root[KB-2:0], ge, t[TB-3:0], 2'b00};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      remx_r[0] <= '0;
      remy_r[0] <= '0;
      rtx_r[0]  <= '0;
      rty_r[0]  <= '0;
      tx_r[0]   <= tx_i;
      ty_r[0]   <= ty_i;
    end
  end

  for (genvar i = 1; i <= KB; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i]                     <= side_r[i-1];
        {remx_r[i], rtx_r[i], tx_r[i]} <= sq_step(remx_r[i-1], rtx_r[i-1], tx_r[i-1]);
        {remy_r[i], rty_r[i], ty_r[i]} <= sq_step(remy_r[i-1], rty_r[i-1], ty_r[i-1]);
      end
    end
  end

  assign v_o    = v_r[KB];
  assign side_o = side_r[KB];
  assign kx_o   = rtx_r[KB];
  assign ky_o   = rty_r[KB];

endmodule

`default_nettype wire

// File: hw/rtl/vector_scale_to_length_top.sv
// ---------------------------------------------------------------------------
// Vector scale-to-length top level
// Scales a signed 2-D vector to a target length, rounding half away from 0.
// ---------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  in       in_valid / in_ready   in_x_in, in_y_in, in_length
//  out      out_valid / out_ready out_x_out, out_y_out, out_zero_vector
//
//  One item enters per cycle while in_ready is high. Items pass through the front
//  end, one divider stage per quotient bit and one root stage per root bit to the
//  output register. Reset clears all valid bits; no clearing pass.
//  A result that is not taken moves into a skid register; the pipeline then
//  holds until the skid register drains, and in_ready follows it.
// ---------------------------------------------------------------------------
`default_nettype none
`include "vector_scale_to_length_top_macros.svh"

module vector_scale_to_length_top #(
  parameter int COORD_BITS  = vstl_pkg::COORD_BITS_DEF,
  parameter int LENGTH_BITS = vstl_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [COORD_BITS-1:0]         in_x_in,
  input  wire logic signed [COORD_BITS-1:0]         in_y_in,
  input  wire logic [LENGTH_BITS-1:0]               in_length,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [vstl_pkg::OUT_BITS-1:0]      out_x_out,
  output logic signed [vstl_pkg::OUT_BITS-1:0]      out_y_out,
  output logic                                      out_zero_vector
);

  localparam int OB = vstl_pkg::OUT_BITS;
  localparam int SB = 2 * COORD_BITS;
  localparam int TB = 2 * LENGTH_BITS + 2;
  localparam int NB = 2 * (LENGTH_BITS + COORD_BITS) + 2;
  localparam int KB = TB / 2;
  localparam int WB = (KB > OB) ? KB : OB;
  localparam logic [OB-1:0] ONE_O = OB'(1);

  logic            en;
  logic            pv, dv, sv;
  vstl_pkg::side_t pside, dside, sside;
  logic [SB-1:0]   s;
  logic [NB-1:0]   nx, ny;
  logic [TB-1:0]   tx, ty;
  logic [KB-1:0]   kx, ky;

  logic [OB-1:0]   rx, ry;
  logic            rz;

  logic            out_v_r, out_v_nxt;
  logic [OB-1:0]   out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic            out_z_r, out_z_nxt;
  logic            skid_v_r, skid_v_nxt;
  logic [OB-1:0]   skid_x_r, skid_x_nxt, skid_y_r, skid_y_nxt;
  logic            skid_z_r, skid_z_nxt;

  assign en       = !skid_v_r;
  assign in_ready = en;

  vstl_prep #(.COORD_BITS(COORD_BITS), .LENGTH_BITS(LENGTH_BITS)) u_prep (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(in_valid && en),
    .x_i(in_x_in), .y_i(in_y_in), .len_i(in_length),
    .v_o(pv), .side_o(pside), .s_o(s), .nx_o(nx), .ny_o(ny)
  );

  vstl_div #(.SB(SB), .TB(TB)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(pv), .side_i(pside),
    .d_i(s), .nx_i(nx), .ny_i(ny),
    .v_o(dv), .side_o(dside), .qx_o(tx), .qy_o(ty)
  );

  vstl_isqrt #(.TB(TB)) u_isqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .v_i(dv), .side_i(dside),
    .tx_i(tx), .ty_i(ty),
    .v_o(sv), .side_o(sside), .kx_o(kx), .ky_o(ky)
  );

  // The rounded magnitude is (k + 1) / 2, where k is the largest odd-or-even
  // integer whose square still fits under the exact quotient.
  function automatic logic [OB-1:0] finish(input logic [KB-1:0] k, input logic neg);
    logic [KB:0]   kp;
    logic [WB-1:0] ne;
    logic [OB-1:0] m;
    kp = {1'b0, k} + {{KB{1'b0}}, 1'b1};
    ne = WB'(kp[KB:1]);
    m  = ne[OB-1:0];
    return neg ? (~m + ONE_O) : m;
  endfunction

  always_comb begin
    rz = sside.zero;
    rx = rz ? '0 : finish(kx, sside.xneg);
    ry = rz ? '0 : finish(ky, sside.yneg);
  end

  always_comb begin
    out_v_nxt  = out_v_r;
    out_x_nxt  = out_x_r;
    out_y_nxt  = out_y_r;
    out_z_nxt  = out_z_r;
    skid_v_nxt = skid_v_r;
    skid_x_nxt = skid_x_r;
    skid_y_nxt = skid_y_r;
    skid_z_nxt = skid_z_r;
    if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end
    if (skid_v_r) begin
      if (!out_v_r || out_ready) begin
        out_v_nxt  = 1'b1;
        out_x_nxt  = skid_x_r;
        out_y_nxt  = skid_y_r;
        out_z_nxt  = skid_z_r;
        skid_v_nxt = 1'b0;
      end
    end else if (sv) begin
      if (out_v_r && !out_ready) begin
        skid_v_nxt = 1'b1;
        skid_x_nxt = rx;
        skid_y_nxt = ry;
        skid_z_nxt = rz;
      end else begin
        out_v_nxt = 1'b1;
        out_x_nxt = rx;
        out_y_nxt = ry;
        out_z_nxt = rz;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r  <= out_x_nxt;
    out_y_r  <= out_y_nxt;
    out_z_r  <= out_z_nxt;
    skid_x_r <= skid_x_nxt;
    skid_y_r <= skid_y_nxt;
    skid_z_r <= skid_z_nxt;
  end

  assign out_valid       = out_v_r;
  assign out_x_out       = out_x_r;
  assign out_y_out       = out_y_r;
  assign out_zero_vector = out_z_r;

  `VSTL_ASSERT_NOW(a_skid_implies_out, skid_v_r, out_v_r, "skid item without output item")
  `VSTL_ASSERT_NOW(a_zero_gives_zero, out_v_r && out_z_r, (out_x_r == '0) && (out_y_r == '0), "zero vector with nonzero result")
  `VSTL_ASSERT_NEXT(a_skid_drains, skid_v_r && out_ready, !skid_v_r, "skid item not drained")
  `VSTL_ASSERT_NOW(a_no_neg_zero, out_v_r, out_x_r != {1'b1, {(OB-1){1'b0}}} || !out_z_r, "malformed zero result")

endmodule

`default_nettype wire
